// ----- rtl/core/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and constants for the line receive FIFO
// Command and result codes, and the controller/datapath request and status
// structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrf_pkg;

  // Default ring depth (one slot stays free)
  localparam int LRF_DEPTH = 64;

  // Field widths fixed by the interface
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POPN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LINE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

  // Newline character
  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // Source of the byte total when a multi-byte read starts
  localparam logic [1:0] TOT_ONE  = 2'd0;
  localparam logic [1:0] TOT_TAKE = 2'd1;
  localparam logic [1:0] TOT_LINE = 2'd2;

  // Requests from the controller to the datapath
  typedef struct packed {
    logic                push;
    logic                flush;
    logic                ld_single;
    logic [STATUS_W-1:0] res_status;
    logic                res_ne;
    logic                start_emit;
    logic [1:0]          tot_sel;
    logic                start_scan;
    logic                scan_step;
    logic                emit_byte;
  } lrf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic limit_zero;
    logic scan_end;
    logic too_long;
    logic newline;
    logic emit_last;
    logic out_free;
  } lrf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrf_ctrl: command sequencer for the line receive FIFO
// Decodes each accepted command and steps the datapath through line scans
// and byte-by-byte reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  input  wire  [lrf_pkg::CMD_W-1:0]   command,
  output logic                        s_tready,
  input  wire  lrf_pkg::lrf_stat_t    stat,
  output lrf_pkg::lrf_cmd_t           cmd
);
  import lrf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_FAIL = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [STATUS_W-1:0] fail_code;
  logic [STATUS_W-1:0] fail_code_next;
  logic                take;

  // Accept a request only out of reset, when idle and the result register can load
  assign s_tready = !rst && (state == S_IDLE) && stat.out_free;
  assign take     = s_tvalid && s_tready;

  // Decode state and command into datapath requests
  always_comb begin
    cmd            = '0;
    state_next     = state;
    fail_code_next = fail_code;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (command)
            CMD_PUSH: begin
              cmd.push       = 1'b1;
              cmd.ld_single  = 1'b1;
              cmd.res_status = stat.full ? ST_FULL : ST_OK;
              cmd.res_ne     = 1'b1;
            end
            CMD_POP: begin
              if (stat.empty) begin
                cmd.ld_single  = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.start_emit = 1'b1;
                cmd.tot_sel    = TOT_ONE;
                state_next     = S_EMIT;
              end
            end
            CMD_POPN: begin
              if (stat.limit_zero) begin
                cmd.ld_single  = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_ne     = !stat.empty;
              end else if (stat.empty) begin
                cmd.ld_single  = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.start_emit = 1'b1;
                cmd.tot_sel    = TOT_TAKE;
                state_next     = S_EMIT;
              end
            end
            CMD_LINE: begin
              if (stat.limit_zero || stat.empty) begin
                cmd.ld_single  = 1'b1;
                cmd.res_status = ST_EMPTY;
                cmd.res_ne     = !stat.empty;
              end else begin
                cmd.start_scan = 1'b1;
                state_next     = S_SCAN;
              end
            end
            CMD_FLUSH: begin
              cmd.flush      = 1'b1;
              cmd.ld_single  = 1'b1;
              cmd.res_status = ST_OK;
            end
            default: begin
              cmd.ld_single  = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_ne     = !stat.empty;
            end
          endcase
        end
      end
      // Walk one stored byte a cycle looking for the newline
      S_SCAN: begin
        if (stat.scan_end) begin
          fail_code_next = ST_EMPTY;
          state_next     = S_FAIL;
        end else if (stat.too_long) begin
          fail_code_next = ST_TOO_LONG;
          state_next     = S_FAIL;
        end else if (stat.newline) begin
          cmd.start_emit = 1'b1;
          cmd.tot_sel    = TOT_LINE;
          state_next     = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      // Deliver one byte whenever the result register frees up
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      // Report a failed line read without consuming anything
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.ld_single  = 1'b1;
          cmd.res_status = fail_code;
          cmd.res_ne     = !stat.empty;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fail_code <= ST_OK;
    end else begin
      state     <= state_next;
      fail_code <= fail_code_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lrf_dp.sv -----
// ----------------------------------------------------------------------------
// lrf_dp: datapath of the line receive FIFO
// Byte ring memory with registered read, read/write/scan pointers, byte
// counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_dp #(
  parameter int DEPTH = lrf_pkg::LRF_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  [lrf_pkg::BYTE_W-1:0]    rx_byte,
  input  wire  [lrf_pkg::CNT_W-1:0]     max_length,
  input  wire  lrf_pkg::lrf_cmd_t       cmd,
  output lrf_pkg::lrf_stat_t            stat,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [lrf_pkg::BYTE_W-1:0]    data_byte,
  output logic                          has_byte,
  output logic [lrf_pkg::CNT_W-1:0]     byte_count,
  output logic [lrf_pkg::STATUS_W-1:0]  status,
  output logic                          not_empty,
  output logic                          last
);
  import lrf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_addr;

  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  sp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  sp_inc;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  total_next;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  limit_sat;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  take;
  logic              final_ne;
  logic              full;

  // Advance pointers with wrap at the ring top
  assign wp_inc  = (wp == PTR_TOP) ? '0 : wp + 1'b1;
  assign rp_inc  = (rp == PTR_TOP) ? '0 : rp + 1'b1;
  assign sp_inc  = (sp == PTR_TOP) ? '0 : sp + 1'b1;
  assign cnt_inc = cnt + 1'b1;

  // Fill level and length limit
  assign full      = (wp_inc == rp);
  assign avail     = CNT_W'(wp) - CNT_W'(rp) + ((wp < rp) ? DEPTH_C : '0);
  assign limit_sat = (max_length > DEPTH_C) ? DEPTH_C : max_length;
  assign take      = (limit_sat < avail) ? limit_sat : avail;

  // Byte total for the read that starts now
  always_comb begin
    case (cmd.tot_sel)
      TOT_ONE:  total_next = CNT_W'(1);
      TOT_TAKE: total_next = take;
      TOT_LINE: total_next = cnt_inc;
      default:  total_next = CNT_W'(1);
    endcase
  end

  // Status towards the controller
  always_comb begin
    stat.empty      = (wp == rp);
    stat.full       = full;
    stat.limit_zero = (max_length == '0);
    stat.scan_end   = (cnt == avail);
    stat.too_long   = (cnt_inc >= limit);
    stat.newline    = (rd_data == NEWLINE);
    stat.emit_last  = (cnt_inc == total);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // Read ahead of the byte that the next cycle needs
  assign rd_addr = cmd.emit_byte ? rp_inc : (cmd.scan_step ? sp_inc : rp);

  // Byte store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[wp] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // Ring pointers and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.flush) begin
        wp <= '0;
        rp <= '0;
      end
      if (cmd.push && !full) begin
        wp <= wp_inc;
      end
      if (cmd.emit_byte) begin
        rp <= rp_inc;
      end
      if (cmd.ld_single || cmd.emit_byte) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Scan pointer, counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      sp    <= rp;
      cnt   <= '0;
      limit <= limit_sat;
    end else if (cmd.scan_step) begin
      sp  <= sp_inc;
      cnt <= cnt_inc;
    end else if (cmd.start_emit) begin
      cnt      <= '0;
      total    <= total_next;
      final_ne <= (total_next != avail);
    end else if (cmd.emit_byte) begin
      cnt <= cnt_inc;
    end

    if (cmd.ld_single) begin
      data_byte  <= '0;
      has_byte   <= 1'b0;
      byte_count <= '0;
      status     <= cmd.res_status;
      not_empty  <= cmd.res_ne;
      last       <= 1'b1;
    end else if (cmd.emit_byte) begin
      data_byte  <= rd_data;
      has_byte   <= 1'b1;
      byte_count <= stat.emit_last ? total : '0;
      status     <= ST_OK;
      not_empty  <= final_ne;
      last       <= stat.emit_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/line_receive_fifo.sv -----
// Single-result commands (push, pop on empty, flush, ...): result registered in
//   the cycle after the request is taken; a new request each cycle while the
//   result is taken. Pop and pop-up-to: the emit state loads the first byte from
//   the registered read port of the store, then one byte a cycle while taken.
// Read line: one byte scanned a cycle, then the line at one byte a cycle while
//   taken, or a fail-state refusal. Reset clears wp and rp; store undefined.
// ----------------------------------------------------------------------------
// line_receive_fifo: receive byte ring buffer with line read
// Stores received bytes, keeps one slot free, and serves single pops, bounded
// pops and newline-terminated line reads as streams of result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module line_receive_fifo #(
  parameter int DEPTH = lrf_pkg::LRF_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // rx_byte[7:0], max_length[14:8], zero[15]
  input  wire  [2:0]  s_tuser,   // command[2:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // data_byte[7:0], byte_count[14:8],
                                 // status[16:15], not_empty[17], zero[23:18]
  output logic        m_tuser,   // has_byte
  output logic        m_tlast
);
  import lrf_pkg::*;

  lrf_cmd_t            cmd;
  lrf_stat_t           stat;
  logic [BYTE_W-1:0]   data_byte;
  logic [CNT_W-1:0]    byte_count;
  logic [STATUS_W-1:0] status;
  logic                not_empty;

  // Sequencer
  lrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .command  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, pointers and result register
  lrf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (s_tdata[7:0]),
    .max_length (s_tdata[14:8]),
    .cmd        (cmd),
    .stat       (stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .data_byte  (data_byte),
    .has_byte   (m_tuser),
    .byte_count (byte_count),
    .status     (status),
    .not_empty  (not_empty),
    .last       (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {6'd0, not_empty, status, byte_count, data_byte};

endmodule

`default_nettype wire

// ----- rtl/core/lrf_checker.sv -----
// ----------------------------------------------------------------------------
// lrf_checker: port-level checks for the line receive FIFO
// Watches the stream ports of the top level and flags request and result sequences that
// the block must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata,
  input wire        m_tuser,
  input wire        m_tlast
);

  // New requests only when the result register can take a result
  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("request taken while result register blocked");

  // A result without a byte closes its command
  a_nobyte_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("byte-less result not marked last");

  // Byte count shows only on the closing result
  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[14:8] == 7'd0))
    else $error("byte count on a non-final result");

  // Delivered bytes always carry ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[16:15] == 2'd0))
    else $error("byte delivered with error status");

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind line_receive_fifo lrf_checker u_lrf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
